@@ rtl/bale_pkg.sv @@
// ----------------------------------------------------------------------------
// bale_pkg
// Shared constants, operation codes and cell control types for the bounded
// array list engine.
// ----------------------------------------------------------------------------
`default_nettype none

package bale_pkg;

	localparam int CAPACITY  = 16;
	localparam int IDX_W     = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W     = $clog2(CAPACITY + 1);
	localparam int OP_W      = 4;
	localparam int DATA_W    = 8;
	localparam int POS_W     = 5;
	localparam int POS_CMP_W = (POS_W > CNT_W) ? POS_W : CNT_W;

	typedef logic [DATA_W-1:0] data_t;

	localparam logic [OP_W-1:0] OP_INS_FIRST  = 4'd0;
	localparam logic [OP_W-1:0] OP_INS_LAST   = 4'd1;
	localparam logic [OP_W-1:0] OP_INS_POS    = 4'd2;
	localparam logic [OP_W-1:0] OP_INS_SORTED = 4'd3;
	localparam logic [OP_W-1:0] OP_INS_UNIQUE = 4'd4;
	localparam logic [OP_W-1:0] OP_DEL_FIRST  = 4'd5;
	localparam logic [OP_W-1:0] OP_DEL_LAST   = 4'd6;
	localparam logic [OP_W-1:0] OP_DEL_ELEM   = 4'd7;
	localparam logic [OP_W-1:0] OP_DEL_ALL    = 4'd8;
	localparam logic [OP_W-1:0] OP_LOCATE     = 4'd9;
	localparam logic [OP_W-1:0] OP_CLEAR      = 4'd10;

	// cell update modes
	localparam logic [1:0] CM_HOLD   = 2'd0;
	localparam logic [1:0] CM_INSERT = 2'd1;
	localparam logic [1:0] CM_DELETE = 2'd2;

	// broadcast from the controller to every cell
	typedef struct packed {
		logic [1:0]       mode;
		logic [CNT_W-1:0] target;
		logic [CNT_W-1:0] count;
		data_t            value;
	} cell_ctl_t;

	// running scan handed from cell to cell
	typedef struct packed {
		logic seen_eq;
		logic seen_le;
	} scan_t;

	// per-cell report back to the controller
	typedef struct packed {
		logic first_eq;
		logic first_le;
		logic slot_dup;
	} hit_t;

endpackage

`default_nettype wire

@@ rtl/bale_in_if.sv @@
// ----------------------------------------------------------------------------
// bale_in_if
// Request channel: operation, byte value and insert position.
// ----------------------------------------------------------------------------
`default_nettype none

interface bale_in_if import bale_pkg::*;;
	logic            valid;
	logic            ready;
	logic [OP_W-1:0] op;
	data_t           value;
	logic [POS_W-1:0] pos;

	modport source(output valid, op, value, pos, input ready);
	modport sink(input valid, op, value, pos, output ready);
endinterface

`default_nettype wire

@@ rtl/bale_out_if.sv @@
// ----------------------------------------------------------------------------
// bale_out_if
// Response channel: status flags, match index and resulting list count.
// ----------------------------------------------------------------------------
`default_nettype none

interface bale_out_if import bale_pkg::*;;
	logic             valid;
	logic             ready;
	logic             ok;
	logic             found;
	logic [IDX_W-1:0] index;
	logic [CNT_W-1:0] count;
	logic             full_res;
	logic             empty_res;

	modport source(output valid, ok, found, index, count, full_res, empty_res, input ready);
	modport sink(input valid, ok, found, index, count, full_res, empty_res, output ready);
endinterface

`default_nettype wire

@@ rtl/bounded_array_list_engine.sv @@
// ----------------------------------------------------------------------------
// bounded_array_list_engine
// Bounded list of byte entries built as a row of compare-and-shift cells.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one operation (op, value, pos); rsp returns one transaction
//   per request with ok, found, index, count, full_res and empty_res.
//   A request is taken while the engine is idle and executed from the
//   cycle after; the response is registered when execution ends, and no
//   new request is taken before then. Delete-all removes one match per
//   cycle through the cell row while the response register is free; its
//   response is registered at the step that finds no match left. Each
//   execute step is one compare across all cells, the first-match scan
//   along the row and one shift into the neighbor.
//   The response sits in an output register; a new request is accepted
//   while it waits. When rsp is stalled, the next request holds in its
//   execute cycle until the response register frees.
//   arst_n empties the list and drops any pending response; entry bytes
//   are not cleared and are only read below the count.
// ----------------------------------------------------------------------------
`default_nettype none

module bounded_array_list_engine import bale_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	bale_in_if.sink    req,
	bale_out_if.source rsp
);

	cell_ctl_t            ctl;
	hit_t [CAPACITY-1:0]  hits;
	scan_t [CAPACITY:0]   scan;
	data_t                entries [CAPACITY];

	assign scan[0] = '0;

	bale_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp),
		.hits   (hits),
		.ctl    (ctl)
	);

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		data_t left_entry;
		data_t right_entry;

		if (i == 0) begin : g_first
			assign left_entry = '0;
		end else begin : g_mid
			assign left_entry = entries[i-1];
		end

		if (i == CAPACITY - 1) begin : g_last
			assign right_entry = '0;
		end else begin : g_inner
			assign right_entry = entries[i+1];
		end

		bale_cell u_cell (
			.clk         (clk),
			.cell_idx    (IDX_W'(i)),
			.ctl         (ctl),
			.left_entry  (left_entry),
			.right_entry (right_entry),
			.scan_in     (scan[i]),
			.scan_out    (scan[i+1]),
			.hit         (hits[i]),
			.entry       (entries[i])
		);
	end

endmodule

`default_nettype wire

@@ rtl/bale_cell.sv @@
// ----------------------------------------------------------------------------
// bale_cell
// One list slot: holds a byte, compares it against the broadcast value,
// extends the first-match scan and shifts from a neighbor on insert/delete.
// ----------------------------------------------------------------------------
`default_nettype none

module bale_cell import bale_pkg::*; (
	input  logic             clk,
	input  logic [IDX_W-1:0] cell_idx,
	input  cell_ctl_t        ctl,
	input  data_t            left_entry,
	input  data_t            right_entry,
	input  scan_t            scan_in,
	output scan_t            scan_out,
	output hit_t             hit,
	output data_t            entry
);

	data_t            entry_q;
	logic [CNT_W-1:0] cell_pos;
	logic             occupied;
	logic             eq;
	logic             le;

	assign cell_pos = CNT_W'(cell_idx);
	assign occupied = cell_pos < ctl.count;
	assign eq       = occupied && (entry_q == ctl.value);
	assign le       = occupied && (ctl.value <= entry_q);

	assign hit.first_eq = eq & ~scan_in.seen_eq;
	assign hit.first_le = le & ~scan_in.seen_le;
	assign hit.slot_dup = le & ~scan_in.seen_le & eq;

	assign scan_out.seen_eq = scan_in.seen_eq | eq;
	assign scan_out.seen_le = scan_in.seen_le | le;

	assign entry = entry_q;

	always_ff @(posedge clk) begin
		case (ctl.mode)
			CM_INSERT: begin
				if (cell_pos == ctl.target) begin
					entry_q <= ctl.value;
				end else if (cell_pos > ctl.target) begin
					entry_q <= left_entry;
				end
			end
			CM_DELETE: begin
				if (cell_pos >= ctl.target) begin
					entry_q <= right_entry;
				end
			end
			default: begin
			end
		endcase
	end

endmodule

`default_nettype wire

@@ rtl/bale_ctrl.sv @@
// ----------------------------------------------------------------------------
// bale_ctrl
// Operation sequencer: takes a request, decodes the cell scan into a target
// position, steers the cell row and registers the response.
// ----------------------------------------------------------------------------
`default_nettype none

module bale_ctrl import bale_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	bale_in_if.sink                req,
	bale_out_if.source             rsp,
	input  hit_t [CAPACITY-1:0]    hits,
	output cell_ctl_t              ctl
);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_EXEC = 1'b1;

	logic             state_q;
	logic [OP_W-1:0]  op_q;
	data_t            value_q;
	logic [POS_W-1:0] pos_q;
	logic [CNT_W-1:0] count_q;
	logic             sweep_q;
	logic             found_q;
	logic [IDX_W-1:0] idx_q;

	logic             rsp_valid_q;
	logic             ok_q;
	logic             rsp_found_q;
	logic [IDX_W-1:0] rsp_idx_q;
	logic [CNT_W-1:0] rsp_count_q;
	logic             full_q;
	logic             empty_q;

	logic             eq_any;
	logic             le_any;
	logic             dup;
	logic [IDX_W-1:0] eq_idx;
	logic [IDX_W-1:0] le_idx;
	logic [CNT_W-1:0] slot;
	logic             full;
	logic             empty;
	logic             pos_ok;
	logic             step_en;

	logic [1:0]       mode;
	logic [CNT_W-1:0] target;
	logic [CNT_W-1:0] next_count;
	logic             ok;
	logic             found;
	logic [IDX_W-1:0] idx;
	logic             done;

	// one-hot first-match flags from the row -> binary positions
	always_comb begin
		eq_any = 1'b0;
		le_any = 1'b0;
		dup    = 1'b0;
		eq_idx = '0;
		le_idx = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			eq_any = eq_any | hits[i].first_eq;
			le_any = le_any | hits[i].first_le;
			dup    = dup | hits[i].slot_dup;
			if (hits[i].first_eq) begin
				eq_idx = eq_idx | IDX_W'(i);
			end
			if (hits[i].first_le) begin
				le_idx = le_idx | IDX_W'(i);
			end
		end
	end

	assign slot    = le_any ? CNT_W'(le_idx) : count_q;
	assign full    = count_q == CNT_W'(CAPACITY);
	assign empty   = count_q == '0;
	assign pos_ok  = POS_CMP_W'(pos_q) <= POS_CMP_W'(count_q);
	assign step_en = (state_q == ST_EXEC) && (!rsp_valid_q || rsp.ready);

	always_comb begin
		mode       = CM_HOLD;
		target     = '0;
		next_count = count_q;
		ok         = 1'b0;
		found      = 1'b0;
		idx        = '0;
		done       = 1'b1;
		case (op_q)
			OP_INS_FIRST: begin
				if (!full) begin
					mode       = CM_INSERT;
					next_count = count_q + 1'b1;
					ok         = 1'b1;
				end
			end
			OP_INS_LAST: begin
				if (!full) begin
					mode       = CM_INSERT;
					target     = count_q;
					next_count = count_q + 1'b1;
					ok         = 1'b1;
				end
			end
			OP_INS_POS: begin
				if (!full && pos_ok) begin
					mode       = CM_INSERT;
					target     = CNT_W'(pos_q);
					next_count = count_q + 1'b1;
					ok         = 1'b1;
				end
			end
			OP_INS_SORTED: begin
				if (!full) begin
					mode       = CM_INSERT;
					target     = slot;
					next_count = count_q + 1'b1;
					ok         = 1'b1;
				end
			end
			OP_INS_UNIQUE: begin
				if (!full && !dup) begin
					mode       = CM_INSERT;
					target     = slot;
					next_count = count_q + 1'b1;
					ok         = 1'b1;
				end
			end
			OP_DEL_FIRST: begin
				if (!empty) begin
					mode       = CM_DELETE;
					next_count = count_q - 1'b1;
					ok         = 1'b1;
				end
			end
			OP_DEL_LAST: begin
				if (!empty) begin
					next_count = count_q - 1'b1;
					ok         = 1'b1;
				end
			end
			OP_DEL_ELEM: begin
				found = eq_any;
				idx   = eq_idx;
				ok    = eq_any;
				if (eq_any) begin
					mode       = CM_DELETE;
					target     = CNT_W'(eq_idx);
					next_count = count_q - 1'b1;
				end
			end
			OP_DEL_ALL: begin
				// drop one match per cycle, while the response register is free, until none is left
				found = sweep_q ? found_q : eq_any;
				idx   = sweep_q ? idx_q : eq_idx;
				ok    = found;
				if (eq_any) begin
					mode       = CM_DELETE;
					target     = CNT_W'(eq_idx);
					next_count = count_q - 1'b1;
					done       = 1'b0;
				end
			end
			OP_LOCATE: begin
				found = eq_any;
				idx   = eq_idx;
				ok    = eq_any;
			end
			OP_CLEAR: begin
				next_count = '0;
				ok         = 1'b1;
			end
			default: begin
			end
		endcase
	end

	assign ctl.mode   = step_en ? mode : CM_HOLD;
	assign ctl.target = target;
	assign ctl.count  = count_q;
	assign ctl.value  = value_q;

	assign req.ready = state_q == ST_IDLE;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			sweep_q     <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (req.valid) begin
						state_q <= ST_EXEC;
						sweep_q <= 1'b0;
					end
				end
				ST_EXEC: begin
					if (step_en) begin
						count_q <= next_count;
						if (done) begin
							state_q <= ST_IDLE;
						end else begin
							sweep_q <= 1'b1;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (step_en && done) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			op_q    <= req.op;
			value_q <= req.value;
			pos_q   <= req.pos;
		end
		// hold the first-pass match of a delete-all sweep
		if (step_en && !sweep_q) begin
			found_q <= found;
			idx_q   <= idx;
		end
		if (step_en && done) begin
			ok_q        <= ok;
			rsp_found_q <= found;
			rsp_idx_q   <= idx;
			rsp_count_q <= next_count;
			full_q      <= next_count == CNT_W'(CAPACITY);
			empty_q     <= next_count == '0;
		end
	end

	assign rsp.valid     = rsp_valid_q;
	assign rsp.ok        = ok_q;
	assign rsp.found     = rsp_found_q;
	assign rsp.index     = rsp_idx_q;
	assign rsp.count     = rsp_count_q;
	assign rsp.full_res  = full_q;
	assign rsp.empty_res = empty_q;

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(CAPACITY))
		else $error("list count above capacity");

	a_accept_exec: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready) |=> (state_q == ST_EXEC))
		else $error("accepted request did not start execution");

	a_no_insert_full: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.mode == CM_INSERT) |-> !full)
		else $error("insert steered into a full list");

	a_idx_without_hit: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && !rsp.found) |-> (rsp.index == '0))
		else $error("nonzero index reported without a match");
`endif

endmodule

`default_nettype wire

@@ sim/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the bounded array list engine. A shadow byte list
// tracks every accepted request and predicts each response. Directed tests
// cover empty and full lists, position limits, sorted and unique inserts,
// match deletes and unused op codes. A random mix then grows and shrinks
// the list. Both channels idle at random, with one calm stretch.
// ----------------------------------------------------------------------------

module tb_top;
	import bale_pkg::*;

	localparam int IDLE_PCT     = 27;
	localparam int RANDOM_ITEMS = 500;
	localparam int PHASE_LEN    = 60;

	typedef struct packed {
		logic             ok;
		logic             found;
		logic [IDX_W-1:0] index;
		logic [CNT_W-1:0] count;
		logic             full_res;
		logic             empty_res;
	} list_rsp_t;

	logic clk = 1'b0;
	logic arst_n;

	bale_in_if  req_if();
	bale_out_if rsp_if();

	bounded_array_list_engine dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_if),
		.rsp    (rsp_if)
	);

	data_t     shadow_list[$];
	list_rsp_t pending_rsp_q[$];
	list_rsp_t rsp_want;
	int        fail_count = 0;
	bit        calm_mode  = 1'b0;

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Apply one operation to the shadow list and return the response it causes.
	function automatic list_rsp_t apply_list_op(logic [OP_W-1:0] op, data_t value,
			logic [POS_W-1:0] pos);
		list_rsp_t r;
		int        hit_at;
		int        slot;
		int        len;
		bit        full;
		r      = '0;
		hit_at = -1;
		slot   = 0;
		len    = shadow_list.size();
		full   = (len >= CAPACITY);
		foreach (shadow_list[i]) begin
			if (hit_at < 0 && shadow_list[i] == value) hit_at = i;
		end
		// sorted slot: before the first entry not smaller than the value
		while (slot < len && value > shadow_list[slot]) slot++;
		case (op)
			OP_INS_FIRST: if (!full) begin
				shadow_list.push_front(value);
				r.ok = 1'b1;
			end
			OP_INS_LAST: if (!full) begin
				shadow_list.push_back(value);
				r.ok = 1'b1;
			end
			OP_INS_POS: if (!full && pos <= len) begin
				shadow_list.insert(pos, value);
				r.ok = 1'b1;
			end
			OP_INS_SORTED: if (!full) begin
				shadow_list.insert(slot, value);
				r.ok = 1'b1;
			end
			OP_INS_UNIQUE: if (!full && (slot == len || shadow_list[slot] != value)) begin
				shadow_list.insert(slot, value);
				r.ok = 1'b1;
			end
			OP_DEL_FIRST: if (len > 0) begin
				void'(shadow_list.pop_front());
				r.ok = 1'b1;
			end
			OP_DEL_LAST: if (len > 0) begin
				void'(shadow_list.pop_back());
				r.ok = 1'b1;
			end
			OP_DEL_ELEM: if (hit_at >= 0) begin
				r.found = 1'b1;
				r.index = IDX_W'(hit_at);
				shadow_list.delete(hit_at);
				r.ok = 1'b1;
			end
			OP_DEL_ALL: if (hit_at >= 0) begin
				r.found = 1'b1;
				r.index = IDX_W'(hit_at);
				for (int i = len - 1; i >= hit_at; i--) begin
					if (shadow_list[i] == value) shadow_list.delete(i);
				end
				r.ok = 1'b1;
			end
			OP_LOCATE: if (hit_at >= 0) begin
				r.found = 1'b1;
				r.index = IDX_W'(hit_at);
				r.ok    = 1'b1;
			end
			OP_CLEAR: begin
				shadow_list.delete();
				r.ok = 1'b1;
			end
			default: ;
		endcase
		r.count     = CNT_W'(shadow_list.size());
		r.full_res  = (shadow_list.size() == CAPACITY);
		r.empty_res = (shadow_list.size() == 0);
		return r;
	endfunction

	task automatic send_item(logic [OP_W-1:0] op, data_t value, logic [POS_W-1:0] pos);
		@(negedge clk);
		while (!calm_mode && $urandom_range(99) < IDLE_PCT) begin
			req_if.valid <= 1'b0;
			@(negedge clk);
		end
		req_if.valid <= 1'b1;
		req_if.op    <= op;
		req_if.value <= value;
		req_if.pos   <= pos;
		do @(posedge clk); while (!req_if.ready);
		pending_rsp_q.push_back(apply_list_op(op, value, pos));
	endtask

	always @(negedge clk) begin
		rsp_if.ready <= calm_mode || ($urandom_range(99) >= IDLE_PCT);
	end

	function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, actual %0d", name, want, got);
			fail_count++;
		end
	endfunction

	always @(posedge clk) begin
		if (arst_n && rsp_if.valid && rsp_if.ready) begin
			if (pending_rsp_q.size() == 0) begin
				$error("response transaction with no request outstanding");
				fail_count++;
			end else begin
				rsp_want = pending_rsp_q.pop_front();
				check_field("ok", 8'(rsp_want.ok), 8'(rsp_if.ok));
				check_field("found", 8'(rsp_want.found), 8'(rsp_if.found));
				check_field("index", 8'(rsp_want.index), 8'(rsp_if.index));
				check_field("count", 8'(rsp_want.count), 8'(rsp_if.count));
				check_field("full_res", 8'(rsp_want.full_res), 8'(rsp_if.full_res));
				check_field("empty_res", 8'(rsp_want.empty_res), 8'(rsp_if.empty_res));
			end
		end
	end

	// Draw a byte that often matches an entry already in the list.
	function automatic data_t pick_value();
		int unsigned roll;
		data_t       corner[6] = '{8'h00, 8'h01, 8'h7F, 8'h80, 8'hFE, 8'hFF};
		roll = $urandom_range(99);
		if (roll < 40 && shadow_list.size() > 0)
			return shadow_list[$urandom_range(shadow_list.size() - 1)];
		if (roll < 70) return corner[$urandom_range(5)];
		return data_t'($urandom_range(255));
	endfunction

	function automatic logic [OP_W-1:0] pick_op(bit grow);
		int unsigned roll;
		roll = $urandom_range(99);
		if (roll < 2) return OP_CLEAR;
		if (roll < 6) return OP_W'($urandom_range(2**OP_W - 1, OP_CLEAR + 1));
		if ((roll < 70) == grow) return OP_W'($urandom_range(OP_INS_UNIQUE, OP_INS_FIRST));
		return OP_W'($urandom_range(OP_LOCATE, OP_DEL_FIRST));
	endfunction

	task automatic test_empty_list();
		send_item(OP_LOCATE, 8'h00, '0);
		send_item(OP_DEL_FIRST, 8'h00, '0);
		send_item(OP_DEL_LAST, 8'hFF, '0);
		send_item(OP_DEL_ELEM, 8'h80, '0);
		send_item(OP_DEL_ALL, 8'hFF, '0);
	endtask

	task automatic test_inserts();
		send_item(OP_INS_POS, 8'h11, 5'd1);   // beyond count: reject
		send_item(OP_INS_POS, 8'h22, 5'd31);
		send_item(OP_INS_POS, 8'h80, 5'd0);
		send_item(OP_INS_FIRST, 8'h00, '0);
		send_item(OP_INS_LAST, 8'hFF, '0);
		send_item(OP_INS_SORTED, 8'h80, '0);
		send_item(OP_INS_UNIQUE, 8'h80, '0);  // already present: reject
		send_item(OP_INS_UNIQUE, 8'h7F, '0);
		send_item(OP_INS_POS, 8'h55, 5'd5);   // append at exactly count
		send_item(OP_INS_POS, 8'hAA, 5'd2);
	endtask

	task automatic test_deletes();
		send_item(OP_LOCATE, 8'h80, '0);
		send_item(OP_DEL_ALL, 8'h80, '0);
		send_item(OP_DEL_ELEM, 8'h12, '0);
		send_item(OP_DEL_ELEM, 8'hFF, '0);
		send_item(OP_DEL_FIRST, 8'h00, '0);
		send_item(OP_DEL_LAST, 8'h00, '0);
	endtask

	task automatic test_unused_ops();
		for (int c = OP_CLEAR + 1; c < 2**OP_W; c++) send_item(OP_W'(c), 8'hFF, 5'd31);
	endtask

	task automatic test_capacity();
		while (shadow_list.size() < CAPACITY) send_item(OP_INS_SORTED, pick_value(), '0);
		for (int c = OP_INS_FIRST; c <= OP_INS_UNIQUE; c++) send_item(OP_W'(c), 8'h01, '0);
		send_item(OP_LOCATE, shadow_list[CAPACITY-1], '0);
		send_item(OP_CLEAR, 8'h00, '0);
	endtask

	task automatic test_random_mix();
		logic [OP_W-1:0]  op;
		logic [POS_W-1:0] pos;
		bit               grow;
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			// alternate growing and shrinking so the count sweeps its range
			grow      = ((n / PHASE_LEN) % 2) == 0;
			calm_mode = (n >= 200 && n < 300);
			op        = pick_op(grow);
			if ($urandom_range(4) == 0)
				pos = POS_W'($urandom_range(2**POS_W - 1));
			else
				pos = POS_W'($urandom_range(shadow_list.size()));
			send_item(op, pick_value(), pos);
		end
		calm_mode = 1'b0;
	endtask

	initial begin
		arst_n       = 1'b0;
		req_if.valid = 1'b0;
		req_if.op    = OP_INS_FIRST;
		req_if.value = '0;
		req_if.pos   = '0;
		rsp_if.ready = 1'b0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_empty_list();
		test_inserts();
		test_deletes();
		test_unused_ops();
		test_capacity();
		test_random_mix();

		@(negedge clk);
		req_if.valid <= 1'b0;
		while (pending_rsp_q.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		if (fail_count == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

	initial begin
		#5_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

endmodule

@@ sim.f @@
rtl/bale_pkg.sv
rtl/bale_in_if.sv
rtl/bale_out_if.sv
rtl/bale_cell.sv
rtl/bale_ctrl.sv
rtl/bounded_array_list_engine.sv
sim/tb_top.sv
